@@ rtl/mbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Mirrored byte memory map package
// Operation codes, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbm_pkg;

   // Operation codes carried in the kind field of a request.
   typedef enum logic [2:0] {
      KIND_READ        = 3'd0,
      KIND_WRITE       = 3'd1,
      KIND_CLEAR_ALL   = 3'd2,
      KIND_CLEAR_RANGE = 3'd3,
      KIND_MIRROR      = 3'd4,
      KIND_RESTORE     = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ACCESS,
      ST_CLEAR,
      ST_MIRROR_A,
      ST_MIRROR_B,
      ST_RESTORE,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep_step;
      logic capture;
      logic access;
      logic clear_step;
      logic mirror_a;
      logic mirror_b;
      logic restore_step;
      logic reply;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type req_kind;
      logic     req_ok;
      logic     sweep_last;
      logic     cur_last;
      logic     out_free;
   } status_type;

endpackage

@@ rtl/mbm_if.sv @@
// ----------------------------------------------------------------------------
// Mirrored byte memory map channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mbm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] addr_a;
   logic [15:0] end_a;
   logic [15:0] addr_b;
   logic [15:0] end_b;
   logic [7:0]  data;

   modport source (output valid, kind, addr_a, end_a, addr_b, end_b, data, input ready);
   modport sink   (input valid, kind, addr_a, end_a, addr_b, end_b, data, output ready);
endinterface

interface mbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       ok;
   logic [7:0] read_data;

   modport source (output valid, ok, read_data, input ready);
   modport sink   (input valid, ok, read_data, output ready);
endinterface

@@ rtl/mbm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mirrored byte memory map controller
// Sequences the clearing pass, single accesses and the range operations.
// ----------------------------------------------------------------------------
module mbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mbm_pkg::status_type status,
   output mbm_pkg::cmd_type    cmd
);

   mbm_pkg::state_type state_ff;
   mbm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbm_pkg::ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbm_pkg::ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = mbm_pkg::ST_IDLE;
            end
         end
         mbm_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!status.req_ok) begin
                  state_in = mbm_pkg::ST_REPLY;
               end else begin
                  case (status.req_kind)
                     mbm_pkg::KIND_READ, mbm_pkg::KIND_WRITE: begin
                        state_in = mbm_pkg::ST_ACCESS;
                     end
                     mbm_pkg::KIND_CLEAR_ALL, mbm_pkg::KIND_CLEAR_RANGE: begin
                        state_in = mbm_pkg::ST_CLEAR;
                     end
                     mbm_pkg::KIND_MIRROR:  state_in = mbm_pkg::ST_MIRROR_A;
                     mbm_pkg::KIND_RESTORE: state_in = mbm_pkg::ST_RESTORE;
                     default:               state_in = mbm_pkg::ST_REPLY;
                  endcase
               end
            end
         end
         mbm_pkg::ST_ACCESS:   state_in = mbm_pkg::ST_REPLY;
         mbm_pkg::ST_CLEAR: begin
            if (status.cur_last) begin
               state_in = mbm_pkg::ST_REPLY;
            end
         end
         mbm_pkg::ST_MIRROR_A: state_in = mbm_pkg::ST_MIRROR_B;
         mbm_pkg::ST_MIRROR_B: begin
            state_in = status.cur_last ? mbm_pkg::ST_REPLY : mbm_pkg::ST_MIRROR_A;
         end
         mbm_pkg::ST_RESTORE: begin
            if (status.cur_last) begin
               state_in = mbm_pkg::ST_REPLY;
            end
         end
         mbm_pkg::ST_REPLY: begin
            if (status.out_free) begin
               state_in = mbm_pkg::ST_IDLE;
            end
         end
         default: state_in = mbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mbm_pkg::ST_SWEEP:    cmd.sweep_step = 1'b1;
         mbm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         mbm_pkg::ST_ACCESS:   cmd.access       = 1'b1;
         mbm_pkg::ST_CLEAR:    cmd.clear_step   = 1'b1;
         mbm_pkg::ST_MIRROR_A: cmd.mirror_a     = 1'b1;
         mbm_pkg::ST_MIRROR_B: cmd.mirror_b     = 1'b1;
         mbm_pkg::ST_RESTORE:  cmd.restore_step = 1'b1;
         mbm_pkg::ST_REPLY:    cmd.reply        = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/mbm_dp.sv @@
// ----------------------------------------------------------------------------
// Mirrored byte memory map datapath
// Request checks, range cursors, remap table, byte store and response register.
// ----------------------------------------------------------------------------
module mbm_dp #(
   parameter int MEM_SIZE = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_kind,
   input  logic [15:0]         req_addr_a,
   input  logic [15:0]         req_end_a,
   input  logic [15:0]         req_addr_b,
   input  logic [15:0]         req_end_b,
   input  logic [7:0]          req_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [7:0]          rsp_read_data,
   input  mbm_pkg::cmd_type    cmd,
   output mbm_pkg::status_type status
);

   localparam int AW = $clog2(MEM_SIZE);
   localparam logic [AW-1:0] LAST = AW'(MEM_SIZE - 1);
   localparam logic [16:0] LIMIT = 17'(MEM_SIZE);

   mbm_pkg::kind_type kind;
   logic              a_below, ea_below, eb_below, req_ok;

   mbm_pkg::kind_type kind_ff;
   logic              ok_ff, pend_ff;
   logic [7:0]        data_ff;
   logic [AW-1:0]     cur_a_ff, cur_a_in, cur_b_ff, cur_b_in, end_ff;
   logic              rsp_valid_ff, rsp_ok_ff;
   logic [7:0]        rsp_data_ff;
   logic              out_free;

   logic              map_wr_en, map_rd_en;
   logic [AW-1:0]     map_wr_addr, map_wr_data, map_rd_addr, map_rd_data;
   logic              byte_wr_en, byte_rd_en;
   logic [AW-1:0]     byte_addr;
   logic [7:0]        byte_wr_data, byte_rd_data;

   // Request checks on the incoming payload.
   assign kind     = mbm_pkg::kind_type'(req_kind);
   assign a_below  = {1'b0, req_addr_a} < LIMIT;
   assign ea_below = {1'b0, req_end_a} < LIMIT;
   assign eb_below = {1'b0, req_end_b} < LIMIT;

   always_comb begin
      case (kind)
         mbm_pkg::KIND_READ, mbm_pkg::KIND_WRITE: req_ok = a_below;
         mbm_pkg::KIND_CLEAR_ALL:                 req_ok = 1'b1;
         mbm_pkg::KIND_CLEAR_RANGE, mbm_pkg::KIND_RESTORE: begin
            req_ok = (req_addr_a <= req_end_a) && ea_below;
         end
         mbm_pkg::KIND_MIRROR: begin
            req_ok = ((req_end_a - req_addr_a) == (req_end_b - req_addr_b)) &&
                     (req_addr_a < req_end_a) && (req_addr_b < req_end_b) &&
                     ea_below && eb_below;
         end
         default: req_ok = 1'b0;
      endcase
   end

   // Cursors walk a range; the mirror cursor follows the first one.
   always_comb begin
      cur_a_in = cur_a_ff;
      cur_b_in = cur_b_ff;
      if (cmd.capture) begin
         cur_a_in = (kind == mbm_pkg::KIND_CLEAR_ALL) ? '0 : req_addr_a[AW-1:0];
         cur_b_in = req_addr_b[AW-1:0];
      end else if (cmd.sweep_step || cmd.clear_step || cmd.restore_step) begin
         cur_a_in = cur_a_ff + AW'(1);
      end else if (cmd.mirror_b) begin
         cur_a_in = cur_a_ff + AW'(1);
         cur_b_in = cur_b_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_a_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_a_ff <= cur_a_in;
         pend_ff  <= cmd.clear_step;
         if (cmd.reply) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_b_ff <= cur_b_in;
      if (cmd.capture) begin
         kind_ff <= kind;
         ok_ff   <= req_ok;
         data_ff <= req_data;
         end_ff  <= (kind == mbm_pkg::KIND_CLEAR_ALL) ? LAST : req_end_a[AW-1:0];
      end
      if (cmd.reply) begin
         rsp_ok_ff   <= ok_ff;
         rsp_data_ff <= (ok_ff && kind_ff == mbm_pkg::KIND_READ) ? byte_rd_data : 8'h00;
      end
   end

   // Remap table: one write and one read each cycle.
   assign map_rd_en   = cmd.capture || cmd.clear_step;
   assign map_rd_addr = cmd.capture ? req_addr_a[AW-1:0] : cur_a_ff;
   assign map_wr_en   = cmd.sweep_step || cmd.mirror_a || cmd.mirror_b || cmd.restore_step;
   assign map_wr_addr = cmd.mirror_b ? cur_b_ff : cur_a_ff;
   assign map_wr_data = cur_a_ff;

   mbm_ram #(
      .WIDTH (AW),
      .DEPTH (MEM_SIZE)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Byte store: addressed by the looked-up cell, or by the cursor while sweeping.
   assign byte_addr    = cmd.sweep_step ? cur_a_ff : map_rd_data;
   assign byte_wr_en   = cmd.sweep_step || pend_ff ||
                         (cmd.access && kind_ff == mbm_pkg::KIND_WRITE);
   assign byte_wr_data = (cmd.access && kind_ff == mbm_pkg::KIND_WRITE) ? data_ff : 8'h00;
   assign byte_rd_en   = cmd.access && kind_ff == mbm_pkg::KIND_READ;

   mbm_ram #(
      .WIDTH (8),
      .DEPTH (MEM_SIZE)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_addr),
      .wr_data (byte_wr_data),
      .rd_en   (byte_rd_en),
      .rd_addr (byte_addr),
      .rd_data (byte_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.req_kind   = kind;
   assign status.req_ok     = req_ok;
   assign status.sweep_last = cur_a_ff == LAST;
   assign status.cur_last   = cur_a_ff == end_ff;
   assign status.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

@@ rtl/mirrored_byte_memory_map.sv @@
// ----------------------------------------------------------------------------
// Mirrored byte memory map
// Byte memory reached through a per-address remap table that lets ranges alias.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MEM_SIZE addresses, one
// address per cycle, that zeroes the byte store and loads the identity map; no
// request is taken until it ends. Each request is one operation and gives one
// response. A read or write goes from transfer to the response register
// through the map lookup, then the byte access. Clearing or restoring a range
// walks it address by address, and clear all walks the whole memory. A mirror
// writes the identity entry and then the alias entry of each address, because
// both go through the single write port of the remap table. A rejected request
// goes straight to its response. The response register lets the next request
// be taken while a response still waits for transfer.
// ----------------------------------------------------------------------------
module mirrored_byte_memory_map #(
   parameter int MEM_SIZE = 65536
) (
   input logic       clock,
   input logic       reset,
   mbm_req_if.sink   req_ch,
   mbm_rsp_if.source rsp_ch
);

   // Commands and status between the sequencer and the datapath.
   mbm_pkg::cmd_type    cmd;
   mbm_pkg::status_type status;

   // The controller owns the request handshake and steps every operation.
   mbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds both memories, the cursors and the response register.
   mbm_dp #(
      .MEM_SIZE (MEM_SIZE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_ch.kind),
      .req_addr_a    (req_ch.addr_a),
      .req_end_a     (req_ch.end_a),
      .req_addr_b    (req_ch.addr_b),
      .req_end_b     (req_ch.end_b),
      .req_data      (req_ch.data),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ok        (rsp_ch.ok),
      .rsp_read_data (rsp_ch.read_data),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

@@ tb/sv/mirrored_byte_memory_map_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mirrored byte memory map testbench
// Sends read, write, clear, mirror and restore requests, some valid and some
// rejected, and checks every response against a model that keeps its own copy
// of the byte store and the remap table. Both channels idle and stall at
// random, and a watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------
module mirrored_byte_memory_map_test;

   localparam int MAP_DEPTH = 65536;
   localparam int RANDOM_REQUESTS = 480;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS = 40;
   // The limit on cycles with no transfer at all must cover the slowest single
   // operation (clear all, a full range, or a half-memory mirror) and the
   // clearing pass after reset.
   localparam int IDLE_LIMIT = 400000;

   // The two kind codes that the block does not define. Both must be rejected.
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] addr_a;
      logic [15:0] end_a;
      logic [15:0] addr_b;
      logic [15:0] end_b;
      logic [7:0]  data;
   } mem_request_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] read_data;
   } mem_reply_type;

   // The scoreboard holds its own byte store and remap table. Each accepted
   // request is applied to them at once, and the reply it should give is
   // queued; responses come back in request order.
   class memory_map_scoreboard;
      bit [7:0]      cells [MAP_DEPTH];
      bit [15:0]     remap [MAP_DEPTH];
      mem_reply_type pending_replies [$];
      int            mismatches;
      int            replies_checked;
      int            rejected;
      int            kind_count [8];

      function new();
         int i;
         for (i = 0; i < MAP_DEPTH; i++) begin
            cells[i] = 8'h00;
            remap[i] = 16'(i);
         end
         mismatches = 0;
         replies_checked = 0;
         rejected = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function int pending_count();
         return pending_replies.size();
      endfunction

      function mem_reply_type predict_reply(mem_request_type r);
         mem_reply_type y;
         int            i;
         int            sa;
         int            ea;
         int            sb;
         int            eb;
         y  = '0;
         sa = int'(r.addr_a);
         ea = int'(r.end_a);
         sb = int'(r.addr_b);
         eb = int'(r.end_b);
         case (r.kind)
            mbm_pkg::KIND_READ: begin
               y.read_data = cells[remap[sa]];
               y.ok = 1'b1;
            end
            mbm_pkg::KIND_WRITE: begin
               cells[remap[sa]] = r.data;
               y.ok = 1'b1;
            end
            mbm_pkg::KIND_CLEAR_ALL: begin
               // Only cells that some address maps to are cleared.
               for (i = 0; i < MAP_DEPTH; i++) cells[remap[i]] = 8'h00;
               y.ok = 1'b1;
            end
            mbm_pkg::KIND_CLEAR_RANGE: begin
               if (sa <= ea) begin
                  for (i = sa; i <= ea; i++) cells[remap[i]] = 8'h00;
                  y.ok = 1'b1;
               end
            end
            mbm_pkg::KIND_MIRROR: begin
               // Both ranges need two bytes or more and the same size. The
               // identity entry goes first, then the alias, so overlapping
               // ranges resolve in address order.
               if (sa < ea && sb < eb && (ea - sa) == (eb - sb)) begin
                  for (i = 0; i <= ea - sa; i++) begin
                     remap[sa + i] = 16'(sa + i);
                     remap[sb + i] = 16'(sa + i);
                  end
                  y.ok = 1'b1;
               end
            end
            mbm_pkg::KIND_RESTORE: begin
               if (sa <= ea) begin
                  for (i = sa; i <= ea; i++) remap[i] = 16'(i);
                  y.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         return y;
      endfunction

      function void note_request(mem_request_type r);
         mem_reply_type y;
         y = predict_reply(r);
         kind_count[r.kind]++;
         if (!y.ok) rejected++;
         pending_replies.push_back(y);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_reply(mem_reply_type got);
         mem_reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("response ok=%0b data=%02h with none expected",
                                      got.ok, got.read_data));
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (got.ok !== want.ok)
               report_mismatch($sformatf("reply %0d ok=%0b, expected %0b",
                                         replies_checked, got.ok, want.ok));
            if (got.read_data !== want.read_data)
               report_mismatch($sformatf("reply %0d read_data=%02h, expected %02h",
                                         replies_checked, got.read_data, want.read_data));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   mbm_req_if req_ch ();
   mbm_rsp_if rsp_ch ();

   memory_map_scoreboard board = new();

   int idle_cycles = 0;

   mirrored_byte_memory_map #(
      .MEM_SIZE(MAP_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Draws the number of cycles a side waits before its next transfer. Now
   // and then a side runs a stretch of transfers with no wait at all.
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic mem_request_type make_request(logic [2:0] kind, int a, int ea, int b,
                                                    int eb, int d);
      mem_request_type r;
      r.kind   = kind;
      r.addr_a = 16'(a);
      r.end_a  = 16'(ea);
      r.addr_b = 16'(b);
      r.end_b  = 16'(eb);
      r.data   = 8'(d);
      return r;
   endfunction

   // Most addresses fall in a small window so that aliases, writes and reads
   // keep meeting one another; some go to the top of memory or anywhere.
   function automatic int pick_addr();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(0, 255);
      if (roll < 8) return $urandom_range(65280, 65535);
      return $urandom_range(0, 65535);
   endfunction

   // Range length minus one: mostly short, rarely a few thousand addresses
   // so that the block's long sweeps are exercised without eating the run.
   function automatic int pick_span(int least);
      if ($urandom_range(0, 59) == 0) return $urandom_range(least, 4095);
      return $urandom_range(least, 63);
   endfunction

   function automatic mem_request_type random_request();
      mem_request_type r;
      int roll;
      int span;
      int sa;
      int sb;
      int t;
      // Fields that an operation does not use still carry random bits.
      r = make_request(mbm_pkg::KIND_READ, $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 255));
      r.addr_a = 16'(pick_addr());
      roll = $urandom_range(0, 999);
      if (roll < 300) begin
         r.kind = mbm_pkg::KIND_READ;
      end else if (roll < 600) begin
         r.kind = mbm_pkg::KIND_WRITE;
      end else if (roll < 700) begin
         r.kind = ($urandom_range(0, 1) != 0) ? mbm_pkg::KIND_CLEAR_RANGE
                                               : mbm_pkg::KIND_RESTORE;
         if (r.kind == mbm_pkg::KIND_RESTORE && $urandom_range(0, 1) != 0)
            r.kind = mbm_pkg::KIND_CLEAR_RANGE;
         span = pick_span(0);
         sa = (int'(r.addr_a) + span > 65535) ? 65535 - span : int'(r.addr_a);
         r.addr_a = 16'(sa);
         r.end_a  = 16'(sa + span);
         if ($urandom_range(0, 6) == 0) begin
            // Reversed bounds, rejected unless the range is a single address.
            r.addr_a = 16'(sa + span);
            r.end_a  = 16'(sa);
         end
      end else if (roll < 780) begin
         r.kind = mbm_pkg::KIND_RESTORE;
         span = pick_span(0);
         sa = (int'(r.addr_a) + span > 65535) ? 65535 - span : int'(r.addr_a);
         r.addr_a = 16'(sa);
         r.end_a  = 16'(sa + span);
         if ($urandom_range(0, 6) == 0) begin
            r.addr_a = 16'(sa + span);
            r.end_a  = 16'(sa);
         end
      end else if (roll < 976) begin
         r.kind = mbm_pkg::KIND_MIRROR;
         span = pick_span(1);
         sa = (int'(r.addr_a) + span > 65535) ? 65535 - span : int'(r.addr_a);
         sb = pick_addr();
         if (sb + span > 65535) sb = 65535 - span;
         r.addr_a = 16'(sa);
         r.end_a  = 16'(sa + span);
         r.addr_b = 16'(sb);
         r.end_b  = 16'(sb + span);
         case ($urandom_range(0, 7))
            0: begin
               // Single-byte ranges are refused.
               r.end_a = r.addr_a;
               r.end_b = r.addr_b;
            end
            1: begin
               // Ranges of different size.
               t = (sb + span + 1 <= 65535) ? sb + span + 1 : sb + span - 1;
               r.end_b = 16'(t);
            end
            2: begin
               r.addr_a = 16'(sa + span);
               r.end_a  = 16'(sa);
            end
            default: begin
            end
         endcase
      end else if (roll < 980) begin
         r.kind = mbm_pkg::KIND_CLEAR_ALL;
      end else begin
         r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
      end
      return r;
   endfunction

   // Waits the given number of cycles with valid low, then offers the
   // request until it transfers. Returns at the falling edge after it.
   task automatic send_request(input mem_request_type r, input int pause);
      if (pause > 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= r.kind;
      req_ch.addr_a <= r.addr_a;
      req_ch.end_a  <= r.end_a;
      req_ch.addr_b <= r.addr_b;
      req_ch.end_b  <= r.end_b;
      req_ch.data   <= r.data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      while (board.pending_count() != 0) @(negedge clock);
   endtask

   // Monitors and watchdog. Both channels are sampled at the rising edge,
   // before the block's own updates of that edge take effect.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request({req_ch.kind, req_ch.addr_a, req_ch.end_a, req_ch.addr_b,
                                req_ch.end_b, req_ch.data});
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_reply({rsp_ch.ok, rsp_ch.read_data});
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side. Each response is preceded by a random stall; twice in the
   // run the sink holds ready low for a long stretch while requests keep
   // coming, so the response register fills and the request side backs up.
   initial begin : response_sink
      int quiet;
      int stall;
      int taken;
      quiet = 0;
      taken = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(quiet);
         if (taken == 40 || taken == 320) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Request side and end of run.
   initial begin : request_source
      mem_request_type directed [$];
      int quiet;
      int k;
      quiet = 0;
      reset = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.kind   = mbm_pkg::KIND_READ;
      req_ch.addr_a = '0;
      req_ch.end_a  = '0;
      req_ch.addr_b = '0;
      req_ch.end_b  = '0;
      req_ch.data   = '0;

      // The opening list walks the corners: both ends of memory, both data
      // extremes, every operation, and each rejection case.
      directed.push_back(make_request(mbm_pkg::KIND_READ, 0, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_WRITE, 0, 0, 0, 0, 8'hFF));
      directed.push_back(make_request(mbm_pkg::KIND_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 8'hA5));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 16'hFFFF, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 0, 0, 0, 0, 0));
      // Top sixteen addresses alias the bottom sixteen cells.
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 0, 15, 16'hFFF0, 16'hFFFF, 0));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 16'hFFF0, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_WRITE, 16'hFFFF, 0, 0, 0, 8'h5A));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 15, 0, 0, 0, 0));
      // Rejected mirrors: single bytes, unequal sizes, reversed bounds.
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 5, 5, 10, 10, 0));
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 0, 3, 8, 12, 0));
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 9, 2, 20, 13, 0));
      // Overlapping ranges, then a clear through the alias.
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 16'h100, 16'h10F, 16'h108,
                                      16'h117, 0));
      directed.push_back(make_request(mbm_pkg::KIND_CLEAR_RANGE, 16'hFFF0, 16'hFFFF,
                                      0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 0, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_CLEAR_RANGE, 16'hFFFF, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_RESTORE, 16'hFFF0, 16'hFFFF, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_RESTORE, 16'hFFFF, 16'hFFFE, 0, 0, 0));
      directed.push_back(make_request(KIND_SPARE_6, 1, 2, 3, 4, 8'h11));
      directed.push_back(make_request(KIND_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      8'hFF));
      directed.push_back(make_request(mbm_pkg::KIND_WRITE, 16'h117, 0, 0, 0, 8'h3C));
      directed.push_back(make_request(mbm_pkg::KIND_CLEAR_ALL, 0, 0, 0, 0, 0));
      directed.push_back(make_request(mbm_pkg::KIND_READ, 16'h10F, 0, 0, 0, 0));
      // Full-memory sweeps: half onto half, then everything back to identity.
      directed.push_back(make_request(mbm_pkg::KIND_MIRROR, 0, 16'h7FFF, 16'h8000,
                                      16'hFFFF, 0));
      directed.push_back(make_request(mbm_pkg::KIND_RESTORE, 0, 16'hFFFF, 0, 0, 0));

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i], draw_wait(quiet));
      req_ch.valid <= 1'b0;
      wait_for_replies();

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         // Halfway through, hold off until every reply is back.
         if (k == RANDOM_REQUESTS / 2) begin
            req_ch.valid <= 1'b0;
            wait_for_replies();
         end
         send_request(random_request(), draw_wait(quiet));
      end
      req_ch.valid <= 1'b0;

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.pending_count() != 0)
         board.report_mismatch($sformatf("%0d replies never arrived", board.pending_count()));

      $display("Covered %0d requests: %0d reads, %0d writes, %0d clear-all, %0d range clears,",
               board.kind_count.sum(), board.kind_count[mbm_pkg::KIND_READ],
               board.kind_count[mbm_pkg::KIND_WRITE],
               board.kind_count[mbm_pkg::KIND_CLEAR_ALL],
               board.kind_count[mbm_pkg::KIND_CLEAR_RANGE]);
      $display("%0d mirrors, %0d restores, %0d undefined kinds; %0d replies, %0d rejected",
               board.kind_count[mbm_pkg::KIND_MIRROR],
               board.kind_count[mbm_pkg::KIND_RESTORE],
               board.kind_count[KIND_SPARE_6] + board.kind_count[KIND_SPARE_7],
               board.replies_checked, board.rejected);
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ mirrored_byte_memory_map.f @@
rtl/mbm_pkg.sv
rtl/mbm_if.sv
rtl/mbm_ram.sv
rtl/mbm_ctrl.sv
rtl/mbm_dp.sv
rtl/mirrored_byte_memory_map.sv
tb/sv/mirrored_byte_memory_map_test.sv
